// ===== hw/rtl/mau_pkg.sv =====
// mau_pkg: shared types and constants for the modular arithmetic unit
// no dependencies
`timescale 1ns / 1ps
package mau_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4
  } op_code_t;

  localparam int unsigned MODULUS_RESET = 32'd1000000007;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_A,
    S_RED_B,
    S_EXEC,
    S_POW_MUL,
    S_POW_SQR,
    S_DIV_FIN,
    S_DONE
  } mau_state_t;

  // request from the sequencer to the shared modular multiplier
  typedef struct packed {
    logic start;
  } mm_ctl_t;

endpackage

// ===== hw/rtl/mau_if.sv =====
// mau_stream_if: valid/ready channel with a parameterized payload
// depends on nothing
`timescale 1ns / 1ps
interface mau_stream_if #(parameter int PW = 32);
  logic          valid;
  logic          ready;
  logic [PW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mau_modmul.sv =====
// mau_modmul: bit-serial modular multiply (a*b mod m), one bit of b per cycle
// also used as plain reduction of a value (1*x mod m); depends on mau_pkg
`timescale 1ns / 1ps
module mau_modmul #(
  parameter int WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  mau_pkg::mm_ctl_t  ctl,
  input  logic [WIDTH-1:0]  a,
  input  logic [WIDTH-1:0]  b,
  input  logic [WIDTH-1:0]  m,
  output logic              done,
  output logic [WIDTH-1:0]  p
);
  import mau_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] mult;
  logic [WIDTH-1:0] bsh;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [WIDTH:0]   dbl;
  logic [WIDTH:0]   dbl_red;
  logic [WIDTH:0]   sum;

  // a must be below m; b may take any value, its bits are folded in
  // one per step so acc stays below m throughout
  always_comb begin
    dbl = {acc, 1'b0};
    dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    sum = dbl_red + (bsh[WIDTH-1] ? {1'b0, mult} : '0);
    if (sum >= {1'b0, m}) begin
      sum = sum - {1'b0, m};
    end
  end

  // msb-first double-and-add
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CW'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc  <= '0;
      mult <= a;
      bsh  <= b;
    end else if (busy) begin
      acc <= sum[WIDTH-1:0];
      bsh <= {bsh[WIDTH-2:0], 1'b0};
    end
  end

  assign p = acc;
endmodule

// ===== hw/rtl/modular_arithmetic_unit.sv =====
// modular_arithmetic_unit: top level, sequencer around a shared modular multiplier
// depends on mau_pkg, mau_stream_if, mau_modmul
//
// channel  | dir | payload
// ---------+-----+-------------------------------------
// cfg      | in  | modulus
// in_ch    | in  | op, operand_a, operand_b
// out_ch   | out | result_value
//
// one beat at a time; each multiply stage holds its state until the multiplier signals done
// reductions of a and b take one multiply each (1*x mod m)
// add/sub/neg: result valid after both reductions and the exec state; mul adds a multiply
// divide adds WIDTH rounds of a multiply (only on a set exponent bit) and a square,
// then the final multiply; b of 0 mod m gives 0; modulus below two: 0 in the cycle after
// the accept; reset loads modulus 1000000007; output holds until taken, input waits;
// a configuration beat goes ahead of an input beat offered in the same cycle
`timescale 1ns / 1ps
module modular_arithmetic_unit #(
  parameter int WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  mau_stream_if.sink           cfg,
  mau_stream_if.sink           in_ch,
  mau_stream_if.source         out_ch
);
  import mau_pkg::*;

  localparam int EW = $clog2(WIDTH + 1);

  mau_state_t       state, state_next;
  logic [WIDTH-1:0] modulus;
  logic [2:0]       op;
  logic [WIDTH-1:0] ra, rb, acc, sq, ex, res;
  logic [WIDTH-1:0] in_hold_a, in_hold_b;
  logic [EW-1:0]    ecnt;
  mm_ctl_t          mm_ctl;
  logic [WIDTH-1:0] mm_a, mm_b, mm_p;
  logic             mm_done;
  logic             small_m;
  logic [WIDTH:0]   addr;
  logic [WIDTH:0]   subr;

  assign small_m = (modulus < WIDTH'(2));
  assign cfg.ready = (state == S_IDLE);
  assign in_ch.ready = (state == S_IDLE) && !cfg.valid;
  assign out_ch.valid = (state == S_DONE);
  assign out_ch.data = res;

  // modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WIDTH'(MODULUS_RESET);
    end else if (cfg.valid && cfg.ready) begin
      modulus <= cfg.data;
    end
  end

  mau_modmul #(.WIDTH(WIDTH)) u_mm (
    .clk(clk), .rst(rst), .ctl(mm_ctl), .a(mm_a), .b(mm_b),
    .m(modulus), .done(mm_done), .p(mm_p)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_ch.valid && in_ch.ready) state_next = small_m ? S_DONE : S_RED_A;
      S_RED_A: if (mm_done) state_next = S_RED_B;
      S_RED_B: if (mm_done) state_next = S_EXEC;
      S_EXEC: begin
        if (op == OP_MUL) state_next = S_DIV_FIN;
        else if (op == OP_DIV) state_next = (rb == '0) ? S_DONE : S_POW_MUL;
        else state_next = S_DONE;
      end
      S_POW_MUL: if (!ex[0] || mm_done) state_next = S_POW_SQR;
      S_POW_SQR: if (mm_done) state_next = (ecnt == EW'(1)) ? S_DIV_FIN : S_POW_MUL;
      S_DIV_FIN: if (mm_done) state_next = S_DONE;
      S_DONE: if (out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // multiplier start pulses and operands
  logic started;
  always_comb begin
    mm_ctl.start = 1'b0;
    mm_a = '0;
    mm_b = '0;
    unique case (state)
      S_RED_A: begin mm_ctl.start = !started; mm_a = WIDTH'(1); mm_b = in_hold_a; end
      S_RED_B: begin mm_ctl.start = !started; mm_a = WIDTH'(1); mm_b = in_hold_b; end
      S_POW_MUL: begin
        mm_ctl.start = !started && ex[0]; mm_a = acc; mm_b = sq;
      end
      S_POW_SQR: begin mm_ctl.start = !started; mm_a = sq; mm_b = sq; end
      S_DIV_FIN: begin
        mm_ctl.start = !started; mm_a = ra; mm_b = (op == OP_MUL) ? rb : acc;
      end
      default: ;
    endcase
  end

  // add and subtract paths
  always_comb begin
    addr = {1'b0, ra} + {1'b0, rb};
    if (addr >= {1'b0, modulus}) addr = addr - {1'b0, modulus};
    subr = {1'b0, ra} + ({1'b0, modulus} - {1'b0, rb});
    if (subr >= {1'b0, modulus}) subr = subr - {1'b0, modulus};
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      started <= 1'b0;
    end else begin
      state <= state_next;
      if (state != state_next || mm_done) started <= 1'b0;
      else if (mm_ctl.start) started <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (in_ch.valid && in_ch.ready) begin
        op        <= in_ch.data[2*WIDTH +: 3];
        in_hold_a <= in_ch.data[0 +: WIDTH];
        in_hold_b <= in_ch.data[WIDTH +: WIDTH];
        res       <= '0;
      end
      S_RED_A: if (mm_done) ra <= mm_p;
      S_RED_B: if (mm_done) rb <= mm_p;
      S_EXEC: begin
        acc  <= WIDTH'(1);
        sq   <= rb;
        ex   <= modulus - WIDTH'(2);
        ecnt <= EW'(WIDTH);
        case (op)
          OP_ADD: res <= addr[WIDTH-1:0];
          OP_SUB: res <= subr[WIDTH-1:0];
          OP_NEG: res <= (ra == '0) ? '0 : modulus - ra;
          default: res <= '0;
        endcase
      end
      S_POW_MUL: if (mm_done) acc <= mm_p;
      S_POW_SQR: if (mm_done) begin
        sq   <= mm_p;
        ex   <= ex >> 1;
        ecnt <= ecnt - 1'b1;
      end
      S_DIV_FIN: if (mm_done) res <= mm_p;
      default: ;
    endcase
  end
endmodule

// ===== hw/rtl/mau_checker.sv =====
// mau_checker: port-level checks for modular_arithmetic_unit, bound to the top
// depends on modular_arithmetic_unit and its mau_stream_if ports
`timescale 1ns / 1ps
module mau_checker #(
  parameter int WIDTH = 32
) (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [WIDTH-1:0] out_data
);
  // no new beat taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  // an accepted beat is not followed by a result shown while input is still ready
  a_result_after_beat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid || !in_ready)
    else $error("result without work");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
endmodule

bind modular_arithmetic_unit mau_checker #(.WIDTH(WIDTH)) u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
